>>> hdl/narma_pkg.sv
// shared types, defaults and register codes for the narma10 series generator
package narma_pkg;

	localparam int ORDER_DEFAULT = 10;

	localparam int COEF_W = 16;

	localparam logic [COEF_W-1:0] COEF_LINEAR_RESET   = 16'd1229;
	localparam logic [COEF_W-1:0] COEF_FEEDBACK_RESET = 16'd205;
	localparam logic [COEF_W-1:0] COEF_INPUT_RESET    = 16'd6144;
	localparam logic [COEF_W-1:0] COEF_BIAS_RESET     = 16'd410;

	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_LINEAR   = 2'd0,
		REG_COEF_FEEDBACK = 2'd1,
		REG_COEF_INPUT    = 2'd2,
		REG_COEF_BIAS     = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [15:0] sample;
		logic        end_of_series;
	} sample_req_t;

	typedef struct packed {
		logic signed [15:0] next_output;
		logic               saturated;
	} result_req_t;

endpackage

>>> hdl/narma_ram.sv
// generic single-write, single-read ram with registered read data
module narma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/narma10_series_generator.sv
// narma10 target generator: history rams, two multiply steps, round and saturate
//
//  channel  | signals                         | moves
//  ---------+---------------------------------+------------------------------------
//  sample   | smp_valid, smp_stall, smp       | u[t] and end_of_series flag
//  result   | res_valid, res_stall, res       | y[t+1] and saturated flag
//  config   | cfg_we, cfg_index, cfg_data     | coefficient writes, no read-back
//
//  each request passes through these steps in order: accept with ram read, ram data
//  and first multiplies, coefficient multiplies, then the sum, rounding and write-back.
//  the rate is set by the feedback of y through the two dependent multiplies.
//  reset clears the histories at once through a fill count; no clearing pass.
//  a stalled result holds the final step until the output register frees up;
//  the next request is still taken while a result waits.
module narma10_series_generator #(
	parameter int ORDER = narma_pkg::ORDER_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 smp_valid,
	output logic                                 smp_stall,
	input  narma_pkg::sample_req_t               smp,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output narma_pkg::result_req_t               res,
	input  logic                                 cfg_we,
	input  logic [narma_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [narma_pkg::COEF_W-1:0]         cfg_data
);

	import narma_pkg::*;

	localparam int PTR_W  = $clog2(ORDER);
	localparam int FILL_W = $clog2(ORDER + 1);
	localparam int WS_W   = 16 + $clog2(ORDER);
	localparam int P1_W   = 16 + WS_W;
	localparam int LIN_W  = 33;
	localparam int FB_W   = 17 + P1_W;
	localparam int INP_W  = 48;
	localparam int SUM_W  = FB_W + 10;
	localparam int R_W    = SUM_W - 32;

	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(ORDER - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ORDER);
	localparam logic [FILL_W-1:0] FILL_WARM = FILL_W'(ORDER - 1);
	localparam logic signed [R_W-1:0] R_MAX = R_W'(32767);
	localparam logic signed [R_W-1:0] R_MIN = -R_W'(32768);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [COEF_W-1:0] coef_linear_q;
	logic [COEF_W-1:0] coef_feedback_q;
	logic [COEF_W-1:0] coef_input_q;
	logic [COEF_W-1:0] coef_bias_q;

	logic [PTR_W-1:0]       wp_q;
	logic [FILL_W-1:0]      fill_q;
	logic signed [15:0]     y_q;
	logic signed [WS_W-1:0] ws_q;
	logic                   res_valid_q;
	result_req_t            res_q;

	// per-request datapath registers
	logic [15:0]             u_q;
	logic                    eos_q;
	logic signed [15:0]      old_y_q;
	logic signed [LIN_W-1:0] lin_q;
	logic signed [P1_W-1:0]  p1_q;
	logic [31:0]             p2_q;
	logic signed [FB_W-1:0]  fb_q;
	logic [INP_W-1:0]        inp_q;

	logic [PTR_W-1:0] wp_next;
	logic [15:0]      out_rdata;
	logic [15:0]      in_rdata;
	logic             accept;
	logic             finish;
	logic             warm;

	logic signed [SUM_W-1:0] sum;
	logic signed [R_W-1:0]   r;
	logic signed [15:0]      y_next;
	logic                    sat_next;

	assign wp_next   = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
	assign smp_stall = (state_q != ST_IDLE);
	assign accept    = smp_valid && (state_q == ST_IDLE);
	assign finish    = (state_q == ST_FIN) && (!res_valid_q || !res_stall);
	assign warm      = (fill_q >= FILL_WARM);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// oldest output sits at the write slot, u[t-ORDER+1] one slot past it
	narma_ram #(.WIDTH(16), .DEPTH(ORDER)) u_out_ram (
		.clk   (clk),
		.we    (finish),
		.waddr (wp_q),
		.wdata (y_next),
		.raddr (wp_q),
		.rdata (out_rdata)
	);

	narma_ram #(.WIDTH(16), .DEPTH(ORDER)) u_in_ram (
		.clk   (clk),
		.we    (finish),
		.waddr (wp_q),
		.wdata (u_q),
		.raddr (wp_next),
		.rdata (in_rdata)
	);

	always_comb begin
		sum = (SUM_W'(lin_q) <<< 20)
			+ (SUM_W'(fb_q) <<< 8)
			+ SUM_W'($signed({1'b0, inp_q}))
			+ (SUM_W'($signed({1'b0, coef_bias_q})) <<< 32)
			+ (SUM_W'(1) <<< 31);
		r = sum[SUM_W-1:32];
		sat_next = 1'b0;
		if (!warm) begin
			y_next = '0;
		end else if (r > R_MAX) begin
			y_next   = 16'sd32767;
			sat_next = 1'b1;
		end else if (r < R_MIN) begin
			y_next   = -16'sd32768;
			sat_next = 1'b1;
		end else begin
			y_next = r[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_q   <= smp.sample;
			eos_q <= smp.end_of_series;
		end
		if (state_q == ST_READ) begin
			// entry only counts once a full window was pushed in this series
			old_y_q <= (fill_q == FILL_FULL) ? $signed(out_rdata) : '0;
			lin_q   <= $signed({1'b0, coef_linear_q}) * y_q;
			p1_q    <= y_q * ws_q;
			p2_q    <= u_q * in_rdata;
		end
		if (state_q == ST_MUL) begin
			fb_q  <= $signed({1'b0, coef_feedback_q}) * p1_q;
			inp_q <= coef_input_q * p2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			coef_linear_q   <= COEF_LINEAR_RESET;
			coef_feedback_q <= COEF_FEEDBACK_RESET;
			coef_input_q    <= COEF_INPUT_RESET;
			coef_bias_q     <= COEF_BIAS_RESET;
			wp_q            <= '0;
			fill_q          <= '0;
			y_q             <= '0;
			ws_q            <= '0;
			res_valid_q     <= 1'b0;
			res_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_COEF_LINEAR:   coef_linear_q   <= cfg_data;
					REG_COEF_FEEDBACK: coef_feedback_q <= cfg_data;
					REG_COEF_INPUT:    coef_input_q    <= cfg_data;
					REG_COEF_BIAS:     coef_bias_q     <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && !res_stall && !finish) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (finish) begin
						state_q           <= ST_IDLE;
						res_valid_q       <= 1'b1;
						res_q.next_output <= y_next;
						res_q.saturated   <= sat_next;
						if (eos_q) begin
							wp_q   <= '0;
							fill_q <= '0;
							y_q    <= '0;
							ws_q   <= '0;
						end else begin
							wp_q   <= wp_next;
							fill_q <= (fill_q == FILL_FULL) ? fill_q : fill_q + FILL_W'(1);
							y_q    <= y_next;
							ws_q   <= ws_q - WS_W'(old_y_q) + WS_W'(y_next);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sim/tb.sv
// self-checking testbench for narma10_series_generator: fixed-point target predictor
module tb;
	import narma_pkg::*;

	localparam int HIST_LEN = ORDER_DEFAULT;

	typedef struct {
		logic [15:0]        sample;
		bit                 eos;
		bit                 typed;
		logic signed [15:0] want_y;
		bit                 want_sat;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   smp_valid = 1'b0;
	logic                   smp_stall;
	sample_req_t            smp = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	result_req_t            res;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_COEF_LINEAR;
	logic [COEF_W-1:0]      cfg_data = '0;

	// predictor state
	logic [COEF_W-1:0]  coef [4];
	logic signed [15:0] out_hist [HIST_LEN];
	logic [15:0]        in_hist [HIST_LEN];
	longint             win_sum;
	int                 warm_cnt;

	result_req_t pending_targets [$];
	int          mismatches = 0;
	bit          calm = 1'b0;
	bit          hold_rx = 1'b0;

	// warmup rows give zero; a zero sample right after warmup gives the bias alone
	stim_row_t directed_rows [24] = '{
		'{16'hFFFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h0000, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h8000, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h0001, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h7FFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hAAAA, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h5555, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h00FF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hFF00, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h0000, 1'b0, 1'b1, 16'sd410, 1'b0},
		'{16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
		'{16'h8000, 1'b0, 1'b0, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b1, 1'b0, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h1234, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h0000, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hC3C3, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h3C3C, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b1, 1'b1, 16'sd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b1, 16'sd0, 1'b0},
		'{16'h0000, 1'b0, 1'b1, 16'sd0, 1'b0}
	};

	narma10_series_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void clear_series();
		for (int k = 0; k < HIST_LEN; k++) begin
			out_hist[k] = '0;
			in_hist[k] = '0;
		end
		win_sum = 0;
		warm_cnt = 0;
	endfunction

	// next target for one accepted request, advancing the series state
	function automatic result_req_t narma_step(sample_req_t s);
		result_req_t r;
		longint y;
		longint ynew;
		longint lin;
		longint fb;
		longint inp;
		longint bias;
		longint acc;
		r = '0;
		ynew = 0;
		if (warm_cnt < HIST_LEN - 1) begin
			warm_cnt++;
		end else begin
			y = out_hist[0];
			lin = (longint'(coef[REG_COEF_LINEAR]) * y) <<< 20;
			fb = (longint'(coef[REG_COEF_FEEDBACK]) * (y * win_sum)) <<< 8;
			inp = longint'(coef[REG_COEF_INPUT])
				* (longint'(s.sample) * longint'(in_hist[HIST_LEN-2]));
			bias = longint'(coef[REG_COEF_BIAS]) <<< 32;
			acc = (lin + fb + inp + bias + (longint'(1) <<< 31)) >>> 32;
			if (acc > 32767) begin
				acc = 32767;
				r.saturated = 1'b1;
			end else if (acc < -32768) begin
				acc = -32768;
				r.saturated = 1'b1;
			end
			ynew = acc;
		end
		r.next_output = ynew[15:0];
		win_sum = win_sum - longint'(out_hist[HIST_LEN-1]) + ynew;
		for (int k = HIST_LEN - 1; k > 0; k--) begin
			out_hist[k] = out_hist[k-1];
			in_hist[k] = in_hist[k-1];
		end
		out_hist[0] = ynew[15:0];
		in_hist[0] = s.sample;
		if (s.end_of_series)
			clear_series();
		return r;
	endfunction

	// result side: random stall plus the long hold-off
	always @(posedge clk) begin
		res_stall <= hold_rx || (!calm && ($urandom_range(99) < 25));
	end

	always @(posedge clk) begin
		result_req_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_targets.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual y=%0d sat=%0b",
					$time, res.next_output, res.saturated);
			end else begin
				want = pending_targets.pop_front();
				if (res.next_output !== want.next_output) begin
					mismatches++;
					$display("%0t: next_output mismatch: expected %0d, actual %0d",
						$time, want.next_output, res.next_output);
				end
				if (res.saturated !== want.saturated) begin
					mismatches++;
					$display("%0t: saturated mismatch: expected %0b, actual %0b",
						$time, want.saturated, res.saturated);
				end
			end
		end
	end

	// called at a rising edge; returns at a rising edge
	task automatic send_sample(input sample_req_t s, input bit typed, input result_req_t want);
		result_req_t predicted;
		smp_valid <= 1'b1;
		smp <= s;
		do @(posedge clk); while (smp_stall);
		predicted = narma_step(s);
		pending_targets.push_back(typed ? want : predicted);
		if (!calm && $urandom_range(99) < 25) begin
			smp_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic write_coefs(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= REG_COEF_LINEAR;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= REG_COEF_FEEDBACK;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_COEF_INPUT;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= REG_COEF_BIAS;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		coef[REG_COEF_LINEAR] = a;
		coef[REG_COEF_FEEDBACK] = b;
		coef[REG_COEF_INPUT] = c;
		coef[REG_COEF_BIAS] = d;
	endtask

	task automatic wait_drained();
		smp_valid <= 1'b0;
		while (pending_targets.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// mostly full-length series with random content, some short or cut off
	task automatic run_series(input int count);
		sample_req_t s;
		result_req_t none;
		int sent;
		int len;
		sent = 0;
		none = '0;
		while (sent < count) begin
			len = ($urandom_range(99) < 15) ? $urandom_range(1, 9) : $urandom_range(10, 60);
			for (int k = 0; k < len && sent < count; k++) begin
				s.sample = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 16'h8000))
					: 16'($urandom_range(0, 16'hFFFF));
				s.end_of_series = (k == len - 1);
				send_sample(s, 1'b0, none);
				sent++;
			end
		end
	endtask

	initial begin
		sample_req_t s;
		result_req_t want;
		coef[REG_COEF_LINEAR] = COEF_LINEAR_RESET;
		coef[REG_COEF_FEEDBACK] = COEF_FEEDBACK_RESET;
		coef[REG_COEF_INPUT] = COEF_INPUT_RESET;
		coef[REG_COEF_BIAS] = COEF_BIAS_RESET;
		clear_series();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 24; i++) begin
			s.sample = directed_rows[i].sample;
			s.end_of_series = directed_rows[i].eos;
			want.next_output = directed_rows[i].want_y;
			want.saturated = directed_rows[i].want_sat;
			send_sample(s, directed_rows[i].typed, want);
		end
		wait_drained();

		// no idling on either side for this stretch
		calm <= 1'b1;
		write_coefs(COEF_LINEAR_RESET, COEF_FEEDBACK_RESET, COEF_INPUT_RESET,
			COEF_BIAS_RESET);
		run_series(200);
		wait_drained();
		calm <= 1'b0;

		write_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_series(150);
		wait_drained();

		// saturating coefficients while the result side holds off
		write_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		fork
			begin
				hold_rx <= 1'b1;
				repeat (400) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		run_series(150);
		wait_drained();

		write_coefs(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 409)),
			16'($urandom_range(0, 8191)), 16'($urandom_range(0, 1024)));
		run_series(300);
		wait_drained();

		write_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_series(200);
		wait_drained();

		write_coefs(COEF_LINEAR_RESET, COEF_FEEDBACK_RESET, COEF_INPUT_RESET,
			COEF_BIAS_RESET);
		run_series(230);
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
